// ===== rtl/core/ddo_pkg.sv =====
// ddo_pkg: shared constants, codes and the cordic arctangent table for the
// differential drive odometry core. No dependencies.
package ddo_pkg;

  localparam int ANGLE_BITS = 16;   // binary angle, full turn is 2^ANGLE_BITS
  localparam int CMD_FRAC   = 14;   // drive command fraction bits
  localparam int TRIG_FRAC  = 30;   // cosine and sine fraction bits
  localparam int ATAN_LEN   = 24;
  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int POS_W      = 32;

  // inverse cordic gain in Q1.30
  localparam logic signed [31:0] CORDIC_K = 32'sd652032874;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_LIDAR = 1'b1
  } op_e;

  typedef enum logic [7:0] {
    REG_TURN_GAIN = 8'd0,
    REG_MOVE_GAIN = 8'd1
  } reg_idx_e;

  // atan(2^-i) with a full turn of 2^32
  function automatic logic signed [31:0] atan_entry(input logic [4:0] idx);
    logic signed [31:0] val;
    case (idx)
      5'd0:    val = 32'sd536870912;
      5'd1:    val = 32'sd316933406;
      5'd2:    val = 32'sd167458907;
      5'd3:    val = 32'sd85004756;
      5'd4:    val = 32'sd42667331;
      5'd5:    val = 32'sd21354465;
      5'd6:    val = 32'sd10679838;
      5'd7:    val = 32'sd5340245;
      5'd8:    val = 32'sd2670163;
      5'd9:    val = 32'sd1335087;
      5'd10:   val = 32'sd667544;
      5'd11:   val = 32'sd333772;
      5'd12:   val = 32'sd166886;
      5'd13:   val = 32'sd83443;
      5'd14:   val = 32'sd41722;
      5'd15:   val = 32'sd20861;
      5'd16:   val = 32'sd10430;
      5'd17:   val = 32'sd5215;
      5'd18:   val = 32'sd2608;
      5'd19:   val = 32'sd1304;
      5'd20:   val = 32'sd652;
      5'd21:   val = 32'sd326;
      5'd22:   val = 32'sd163;
      5'd23:   val = 32'sd81;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/core/ddo_cordic.sv =====
// ddo_cordic: iterative rotation-mode cordic, one micro-rotation per cycle
// through a shared shift/add unit. Depends on ddo_pkg.
module ddo_cordic #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ddo_pkg::ANGLE_BITS-1:0] angle_i,
  output logic                         done_o,
  output logic signed [31:0]           cos_o,
  output logic signed [31:0]           sin_o
);
  import ddo_pkg::*;

  localparam int CntW = $clog2(TRIG_ITERATIONS + 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [1:0]         quad_q, quad_d;
  logic signed [31:0] x_q, x_d, y_q, y_d, r_q, r_d;

  logic [31:0]        z, zq, u;
  logic signed [31:0] sx, sy, tab;

  always_comb begin
    z   = 32'(angle_i) << (32 - ANGLE_BITS);
    zq  = z + 32'h2000_0000;
    u   = z - {zq[31:30], 30'd0};
    sx  = x_q >>> cnt_q;
    sy  = y_q >>> cnt_q;
    tab = atan_entry(5'(cnt_q));
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quad_d = quad_q;
    x_d    = x_q;
    y_d    = y_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quad_d = zq[31:30];
      x_d    = CORDIC_K;
      y_d    = '0;
      r_d    = $signed(u);
    end else if (busy_q) begin
      if (!r_q[31]) begin
        x_d = x_q - sy;
        y_d = y_q + sx;
        r_d = r_q - tab;
      end else begin
        x_d = x_q + sy;
        y_d = y_q - sx;
        r_d = r_q + tab;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(TRIG_ITERATIONS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quad_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      quad_q <= quad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    r_q <= r_d;
  end

  // put the removed quadrant back
  always_comb begin
    case (quad_q)
      2'd0: begin
        cos_o = x_q;
        sin_o = y_q;
      end
      2'd1: begin
        cos_o = -y_q;
        sin_o = x_q;
      end
      2'd2: begin
        cos_o = -x_q;
        sin_o = -y_q;
      end
      default: begin
        cos_o = y_q;
        sin_o = -x_q;
      end
    endcase
  end

  assign done_o = done_q;

endmodule

// ===== rtl/core/ddo_mac.sv =====
// ddo_mac: shared signed multiplier with a product register, followed by
// round-half-up rescaling and a saturating position add. Depends on ddo_pkg.
module ddo_mac (
  input  logic                                clk_i,
  input  logic                                mul_en_i,
  input  logic signed [ddo_pkg::MUL_A_W-1:0]  a_i,
  input  logic signed [ddo_pkg::MUL_B_W-1:0]  b_i,
  input  logic signed [ddo_pkg::POS_W-1:0]    base_i,
  output logic signed [ddo_pkg::MUL_A_W-1:0]  rnd14_o,
  output logic signed [ddo_pkg::POS_W-1:0]    sum_o
);
  import ddo_pkg::*;

  localparam logic signed [PROD_W-1:0] Half14 = PROD_W'(1) << (CMD_FRAC - 1);
  localparam logic signed [PROD_W-1:0] Half30 = PROD_W'(1) << (TRIG_FRAC - 1);

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] p14, p30;
  logic signed [26:0]       r30;
  logic signed [POS_W:0]    sum_w;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  always_comb begin
    p14     = (prod_q + Half14) >>> CMD_FRAC;
    p30     = (prod_q + Half30) >>> TRIG_FRAC;
    rnd14_o = p14[MUL_A_W-1:0];
    r30     = p30[26:0];
    sum_w   = (POS_W+1)'(base_i) + (POS_W+1)'(r30);
    // clamp to the signed 32-bit range
    if (sum_w[POS_W] != sum_w[POS_W-1]) begin
      sum_o = sum_w[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      sum_o = sum_w[POS_W-1:0];
    end
  end

endmodule

// ===== rtl/core/diff_drive_odometry_lidar_project_core.sv =====
// Differential drive pose keeper with lidar point projection: the sequencer,
// pose and gain registers. Depends on ddo_pkg, ddo_cordic and ddo_mac.
//
// Usage: configuration writes (cfg_valid_i/cfg_ready_o, cfg_ready_o always high;
// index 0 = turn gain, 1 = move gain, other indexes ignored) are to be made only
// while the block is idle, which it does not enforce. Requests enter on in_valid_i/in_ready_o.
// A tick request (operation 0) turns the heading, moves the pose along the new
// heading and returns the pose; a lidar request (operation 1) returns the
// projected point and leaves the pose alone. Exactly one result per request
// leaves on out_valid_o/out_ready_i.
// Sequence: a tick steps through turn, move, cordic start, cordic wait, x
// product, y product, y add and done; a lidar request starts at cordic start.
// The cordic runs one micro-rotation per cycle and the shared multiplier
// registers each product. in_ready_o is high only while the sequencer is
// idle, so one request is in flight at a time.
// The result sits in an output register: a new request is accepted while a
// finished result still waits, and its own result waits in the last step until
// the output register is free.
// Reset clears the pose and heading to zero and loads the gains to their
// defaults (2086 and 655); no result is pending after reset.
module diff_drive_odometry_lidar_project_core #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [15:0] left_drive_i,
  input  logic signed [15:0] right_drive_i,
  input  logic [23:0]        range_reading_i,
  input  logic [15:0]        scan_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic signed [31:0] x_pos_o,
  output logic signed [31:0] y_pos_o,
  output logic [15:0]        heading_out_o
);
  import ddo_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_TURN      = 9'b000000010,
    S_MOVE      = 9'b000000100,
    S_TRIG_GO   = 9'b000001000,
    S_TRIG_WAIT = 9'b000010000,
    S_MULX      = 9'b000100000,
    S_MULY      = 9'b001000000,
    S_ADDY      = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_e;

  localparam logic [ANGLE_BITS-1:0] Quarter = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  state_e state_q, state_d;

  logic [15:0]               turn_gain_q, move_gain_q;
  logic signed [POS_W-1:0]   pose_x_q, pose_y_q;
  logic [ANGLE_BITS-1:0]     heading_q;
  logic                      op_q;
  logic signed [15:0]        left_q, right_q;
  logic [15:0]               scan_q;
  logic signed [MUL_A_W-1:0] opnd_q;
  logic signed [POS_W-1:0]   res_x_q, res_y_q;
  logic                      out_valid_q;
  logic                      kind_q;
  logic signed [POS_W-1:0]   out_x_q, out_y_q;
  logic [15:0]               out_h_q;

  logic                      accept, out_free, is_tick;
  logic signed [16:0]        diff, total;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a, rnd14;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [POS_W-1:0]   base, sum;
  logic                      trig_start, trig_done;
  logic [ANGLE_BITS-1:0]     trig_angle;
  logic signed [31:0]        cos_w, sin_w;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign is_tick     = (op_q == OP_TICK);
  assign diff        = 17'(left_q) - 17'(right_q);
  assign total       = 17'(left_q) + 17'(right_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_gain_q <= 16'd2086;
      move_gain_q <= 16'd655;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TURN_GAIN: turn_gain_q <= cfg_data_i;
        REG_MOVE_GAIN: move_gain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (operation_i == OP_TICK) ? S_TURN : S_TRIG_GO;
        end
      end
      S_TURN:      state_d = S_MOVE;
      S_MOVE:      state_d = S_TRIG_GO;
      S_TRIG_GO:   state_d = S_TRIG_WAIT;
      S_TRIG_WAIT: begin
        if (trig_done) begin
          state_d = S_MULX;
        end
      end
      S_MULX:      state_d = S_MULY;
      S_MULY:      state_d = S_ADDY;
      S_ADDY:      state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = opnd_q;
    mul_b  = cos_w;
    case (state_q)
      S_TURN: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(turn_gain_q));
        mul_b  = MUL_B_W'(diff);
      end
      S_MOVE: begin
        mul_en = 1'b1;
        mul_a  = $signed(MUL_A_W'(move_gain_q));
        mul_b  = MUL_B_W'(total);
      end
      S_MULX: begin
        mul_en = 1'b1;
        mul_b  = cos_w;
      end
      S_MULY: begin
        mul_en = 1'b1;
        mul_b  = sin_w;
      end
      default: ;
    endcase
  end

  assign base       = (state_q == S_ADDY) ? pose_y_q : pose_x_q;
  assign trig_start = (state_q == S_TRIG_GO);
  assign trig_angle = is_tick ? heading_q : heading_q + Quarter + ANGLE_BITS'(scan_q);

  ddo_mac u_mac (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .base_i   (base),
    .rnd14_o  (rnd14),
    .sum_o    (sum)
  );

  ddo_cordic #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .angle_i (trig_angle),
    .done_o  (trig_done),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_TICK;
      heading_q   <= '0;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        op_q <= operation_i;
      end
      if (state_q == S_MOVE) begin
        heading_q <= heading_q + ANGLE_BITS'(rnd14);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        if (is_tick) begin
          pose_x_q <= res_x_q;
          pose_y_q <= res_y_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q  <= left_drive_i;
      right_q <= right_drive_i;
      scan_q  <= scan_angle_i;
      opnd_q  <= $signed(MUL_A_W'(range_reading_i));
    end
    // move distance replaces the range operand on ticks
    if (state_q == S_TRIG_GO && is_tick) begin
      opnd_q <= rnd14;
    end
    if (state_q == S_MULY) begin
      res_x_q <= sum;
    end
    if (state_q == S_ADDY) begin
      res_y_q <= sum;
    end
    if (state_q == S_DONE && out_free) begin
      kind_q  <= op_q;
      out_x_q <= res_x_q;
      out_y_q <= res_y_q;
      out_h_q <= is_tick ? 16'(heading_q) : 16'(heading_q + ANGLE_BITS'(scan_q));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign x_pos_o       = out_x_q;
  assign y_pos_o       = out_y_q;
  assign heading_out_o = out_h_q;

endmodule

// ===== rtl/core/ddo_checker.sv =====
// ddo_checker: port-level checks on the odometry core's request and result
// channels, bound to the top level. Depends on the top level's ports only.
module ddo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [7:0]         cfg_index_i,
  input logic [15:0]        cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               operation_i,
  input logic signed [15:0] left_drive_i,
  input logic signed [15:0] right_drive_i,
  input logic [23:0]        range_reading_i,
  input logic [15:0]        scan_angle_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               result_kind_o,
  input logic signed [31:0] x_pos_o,
  input logic signed [31:0] y_pos_o,
  input logic [15:0]        heading_out_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(x_pos_o) &&
      $stable(y_pos_o) && $stable(heading_out_o) && $stable(result_kind_o))
    else $error("result changed while stalled");

  // one request in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // a result never appears in the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##1 !$rose(out_valid_o))
    else $error("result too early");

  // a new result comes only from a busy sequencer
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without work");

endmodule

bind diff_drive_odometry_lidar_project_core ddo_checker u_ddo_checker (.*);
